### design/wc3_pkg.sv
package wc3_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 8;
    localparam int LWIDTH_W   = 11;
    localparam int SHIFT_W    = 4;
    localparam int COEF_ROW_W = 24;
    localparam int VALUE_W    = 20;
    localparam int OCOL_W     = 10;
    localparam int OROW_W     = 12;
    localparam int PART_W     = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_PAD_W  = OUT_DATA_W - VALUE_W - OCOL_W - OROW_W;

    localparam logic [LWIDTH_W-1:0] LWIDTH_RESET = 11'd1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEFF_TOP    = 3'd0,
        CFG_COEFF_MIDDLE = 3'd1,
        CFG_COEFF_BOTTOM = 3'd2,
        CFG_LINE_WIDTH   = 3'd3,
        CFG_RESULT_SHIFT = 3'd4
    } cfg_index_t;

    // One window column, top row first.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } pix_col_t;

    typedef struct packed {
        logic [COEF_W-1:0] top;
        logic [COEF_W-1:0] mid;
        logic [COEF_W-1:0] bot;
    } coef_col_t;

    // Packed so that value lands in the low bits of the output beat.
    typedef struct packed {
        logic [OROW_W-1:0]  row;
        logic [OCOL_W-1:0]  column;
        logic [VALUE_W-1:0] value;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } res_beat_t;

    typedef struct packed {
        logic              emit;
        logic [OCOL_W-1:0] column;
        logic [OROW_W-1:0] row;
    } meta_t;

endpackage

### design/window_convolution_3x3_core.sv
// 3x3 window correlation over a raster pixel stream.
//
// Input channel (s_*): one pixel per beat in raster order, tdata[7:0] is the
// unsigned sample, tuser[0] marks the first pixel of a frame and clears the
// column and row counters before that pixel is placed.
// Output channel (m_*): one beat for every position where the whole 3x3
// window lies inside the image; it carries the arithmetically shifted
// weighted sum and the window's top-left column and row.
// Configuration channel (cfg_*): index/data writes, always ready; write it
// only while the block is idle.
//
// Throughput is one pixel per clock while s_tready is high: the line buffers
// take one read and one write per port each cycle, and the three window
// cells multiply in parallel. A result passes to m_tvalid through the line
// buffer read, the window shift, the column products, then the sum and
// shift into the output register.
// When the receiver stalls, the output register holds its beat and a skid
// register catches the next one; only then does s_tready drop and the whole
// pipeline freeze, so nothing is lost or repeated.
// Reset clears the counters, valid flags and configuration (line width 1024,
// coefficients and shift zero). The line buffers are not cleared: every entry
// is rewritten before a result depends on it.
module window_convolution_3x3_core
    import wc3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] pixel
    input  logic [0:0]            s_tuser,   // [0] frame_start
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [19:0] filtered_value, [29:20] out_column,
                                             // [41:30] out_row, [47:42] zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COEF_ROW_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int UW = (CW + 1 > LWIDTH_W) ? CW + 1 : LWIDTH_W;

    // Configuration registers
    logic [COEF_ROW_W-1:0] coeff_top_reg;
    logic [COEF_ROW_W-1:0] coeff_mid_reg;
    logic [COEF_ROW_W-1:0] coeff_bot_reg;
    logic [LWIDTH_W-1:0]   line_width_reg;
    logic [SHIFT_W-1:0]    result_shift_reg;

    // Position counters
    logic [CW-1:0]     col_reg;
    logic [CW-1:0]     col_next;
    logic [OROW_W-1:0] row_reg;
    logic [OROW_W-1:0] row_next;

    logic [UW-1:0]     lw_ext;
    logic [UW-1:0]     width_used;
    logic              en;
    logic              accept;
    logic [PIX_W-1:0]  pix_in;
    logic [CW-1:0]     col_base;
    logic [CW-1:0]     col_cur;
    logic [OROW_W-1:0] row_base;
    logic              row_last;
    meta_t             meta_now;

    // Pipeline stage registers
    logic              valid_a_reg;
    logic [PIX_W-1:0]  pix_a_reg;
    logic [CW-1:0]     col_a_reg;
    meta_t             meta_a_reg;
    meta_t             meta_b_reg;
    meta_t             meta_c_reg;

    logic [PIX_W-1:0]         up1;
    logic [PIX_W-1:0]         up2;
    pix_col_t                 pix_chain [0:3];
    coef_col_t                coef_col  [0:2];
    logic signed [PART_W-1:0] part      [0:2];
    logic signed [VALUE_W-1:0] total;
    res_beat_t                res_beat;
    result_t                  out_res;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_top_reg    <= '0;
            coeff_mid_reg    <= '0;
            coeff_bot_reg    <= '0;
            line_width_reg   <= LWIDTH_RESET;
            result_shift_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_COEFF_TOP:    coeff_top_reg    <= cfg_data;
                CFG_COEFF_MIDDLE: coeff_mid_reg    <= cfg_data;
                CFG_COEFF_BOTTOM: coeff_bot_reg    <= cfg_data;
                CFG_LINE_WIDTH:   line_width_reg   <= cfg_data[LWIDTH_W-1:0];
                CFG_RESULT_SHIFT: result_shift_reg <= cfg_data[SHIFT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp the row width into the range the line buffers support
    always_comb
    begin
        lw_ext = UW'(line_width_reg);
        if (lw_ext < UW'(3))
        begin
            width_used = UW'(3);
        end
        else if (lw_ext > UW'(MAX_WIDTH))
        begin
            width_used = UW'(MAX_WIDTH);
        end
        else
        begin
            width_used = lw_ext;
        end
    end

    // Stage A: position of the incoming pixel, line buffer read
    assign en     = s_tready;
    assign accept = s_tvalid && en;
    assign pix_in = s_tdata[PIX_W-1:0];

    always_comb
    begin
        col_base = s_tuser[0] ? '0 : col_reg;
        row_base = s_tuser[0] ? '0 : row_reg;
        col_cur  = (UW'(col_base) >= width_used) ? '0 : col_base;
        row_last = (UW'(col_cur) + UW'(1)) >= width_used;
        if (row_last)
        begin
            col_next = '0;
            row_next = row_base + OROW_W'(1);
        end
        else
        begin
            col_next = col_cur + CW'(1);
            row_next = row_base;
        end
        meta_now.emit   = (col_cur >= CW'(2)) && (row_base >= OROW_W'(2));
        meta_now.column = OCOL_W'(col_cur - CW'(2));
        meta_now.row    = row_base - OROW_W'(2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            valid_a_reg <= 1'b0;
            meta_b_reg  <= '0;
            meta_c_reg  <= '0;
        end
        else if (en)
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            valid_a_reg <= accept;
            meta_b_reg  <= '{emit:   valid_a_reg && meta_a_reg.emit,
                             column: meta_a_reg.column,
                             row:    meta_a_reg.row};
            meta_c_reg  <= meta_b_reg;
        end
    end

    // Hold the pixel and its position beside the line buffer read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_a_reg  <= pix_in;
            col_a_reg  <= col_cur;
            meta_a_reg <= meta_now;
        end
    end

    wc3_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .clk      (clk),
        .en       (en),
        .rd_addr  (col_cur),
        .wr1_en   (accept),
        .wr1_data (pix_in),
        .wr2_en   (en && valid_a_reg),
        .wr2_addr (col_a_reg),
        .wr2_data (up1),
        .up1      (up1),
        .up2      (up2)
    );

    // Stage B/C: window cells, right column fed from the line buffers.
    // Cell k holds window column k and the sum of its three column products.
    assign pix_chain[3] = '{top: up2, mid: up1, bot: pix_a_reg};

    for (genvar k = 0; k < 3; k++)
    begin : g_cell
        assign coef_col[k] = '{top: coeff_top_reg[COEF_W*k +: COEF_W],
                               mid: coeff_mid_reg[COEF_W*k +: COEF_W],
                               bot: coeff_bot_reg[COEF_W*k +: COEF_W]};

        wc3_cell u_cell (
            .clk     (clk),
            .en      (en),
            .shift   (valid_a_reg),
            .pix_in  (pix_chain[k+1]),
            .coef    (coef_col[k]),
            .pix_out (pix_chain[k]),
            .partial (part[k])
        );
    end

    // Final sum and shift, into the output register or its skid register
    always_comb
    begin
        total              = VALUE_W'(part[0]) + VALUE_W'(part[1]) + VALUE_W'(part[2]);
        res_beat.valid     = en && meta_c_reg.emit;
        res_beat.data.value  = total >>> result_shift_reg;
        res_beat.data.column = meta_c_reg.column;
        res_beat.data.row    = meta_c_reg.row;
    end

    wc3_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_beat   (res_beat),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_res};

endmodule

### design/wc3_line_buf.sv
module wc3_line_buf
    import wc3_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             clk,
    input  logic             en,
    input  logic [AW-1:0]    rd_addr,
    input  logic             wr1_en,
    input  logic [PIX_W-1:0] wr1_data,
    input  logic             wr2_en,
    input  logic [AW-1:0]    wr2_addr,
    input  logic [PIX_W-1:0] wr2_data,
    output logic [PIX_W-1:0] up1,
    output logic [PIX_W-1:0] up2
);

    logic [PIX_W-1:0] line1_mem [DEPTH];
    logic [PIX_W-1:0] line2_mem [DEPTH];
    logic [PIX_W-1:0] up1_reg;
    logic [PIX_W-1:0] up2_reg;

    // Row above: read old entry, then overwrite with the new pixel.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            up1_reg <= line1_mem[rd_addr];
        end
        if (wr1_en)
        begin
            line1_mem[rd_addr] <= wr1_data;
        end
    end

    // Two rows above: refilled from the row above through the registered read up1, at wr2_addr.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            up2_reg <= line2_mem[rd_addr];
        end
        if (wr2_en)
        begin
            line2_mem[wr2_addr] <= wr2_data;
        end
    end

    assign up1 = up1_reg;
    assign up2 = up2_reg;

endmodule

### design/wc3_cell.sv
module wc3_cell
    import wc3_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic                     shift,
    input  pix_col_t                 pix_in,
    input  coef_col_t                coef,
    output pix_col_t                 pix_out,
    output logic signed [PART_W-1:0] partial
);

    pix_col_t                 pix_reg;
    logic signed [PART_W-1:0] partial_reg;
    logic signed [PART_W-1:0] partial_next;
    logic signed [16:0]       prod_top;
    logic signed [16:0]       prod_mid;
    logic signed [16:0]       prod_bot;

    always_comb
    begin
        prod_top     = $signed({1'b0, pix_reg.top}) * $signed(coef.top);
        prod_mid     = $signed({1'b0, pix_reg.mid}) * $signed(coef.mid);
        prod_bot     = $signed({1'b0, pix_reg.bot}) * $signed(coef.bot);
        partial_next = PART_W'(prod_top) + PART_W'(prod_mid) + PART_W'(prod_bot);
    end

    // Take the column from the right neighbour on each pixel.
    always_ff @(posedge clk)
    begin
        if (en && shift)
        begin
            pix_reg <= pix_in;
        end
        if (en)
        begin
            partial_reg <= partial_next;
        end
    end

    assign pix_out = pix_reg;
    assign partial = partial_reg;

endmodule

### design/wc3_out_buf.sv
module wc3_out_buf
    import wc3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  res_beat_t in_beat,
    output logic      ready,
    output logic      out_valid,
    output result_t   out_data,
    input  logic      out_ready
);

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    take;

    always_comb
    begin
        take            = out_valid_reg && out_ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_beat.valid)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_next  = in_beat.data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = in_beat.data;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign ready     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### design/wc3_checker.sv
module wc3_checker
    import wc3_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // No result survives reset.
    a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> !m_tvalid)
        else $error("result beat presented straight after reset");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result beat changed");

    // Input back-pressure only starts from a stalled output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without an output stall");

    // While the input is stalled a result is always on offer.
    a_stall_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result pending");

endmodule

bind window_convolution_3x3_core wc3_checker u_checker (.*);
